// ===== hw/rtl/pfes_pkg.sv =====
// Package for the pinned FIFO eviction store.
// Holds sizes, operation and status codes and the entry and result types.
// No dependencies.
package pfes_pkg;

  // Table size and derived widths.
  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int MAX_RES     = MAX_ENTRIES + 1;
  localparam int RES_AW      = $clog2(MAX_RES);

  // Configuration port.
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_ARENA = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOT  = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [23:0] ARENA_RST = 24'd4194304;
  localparam logic [15:0] BOOT_RST  = 16'd1;

  // Operation codes.
  localparam logic [2:0] OP_INIT   = 3'd0;
  localparam logic [2:0] OP_ADD    = 3'd1;
  localparam logic [2:0] OP_REMOVE = 3'd2;
  localparam logic [2:0] OP_PIN    = 3'd3;
  localparam logic [2:0] OP_UNPIN  = 3'd4;
  localparam logic [2:0] OP_FIND   = 3'd5;
  localparam logic [2:0] OP_READ   = 3'd6;
  localparam logic [2:0] OP_CLEAR  = 3'd7;

  // Status codes.
  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_NOTFOUND = 3'd1;
  localparam logic [2:0] STAT_TOOBIG   = 3'd2;
  localparam logic [2:0] STAT_NOROOM   = 3'd3;
  localparam logic [2:0] STAT_RELEASED = 3'd4;

  // One stored entry.
  typedef struct packed {
    logic [31:0] id;
    logic [7:0]  mode;
    logic [23:0] jpeg_len;
    logic [23:0] raw_len;
    logic [31:0] jpeg_handle;
    logic [31:0] raw_handle;
    logic        pinned;
  } ent_t;

  // One queued result, before count and byte total are attached.
  typedef struct packed {
    logic [2:0] status;
    ent_t       ent;
  } res_t;

  localparam int RES_W = $bits(res_t);

  // Table update commands.
  typedef enum logic [2:0] {
    TBL_NONE,
    TBL_INSERT,
    TBL_DROP,
    TBL_PIN_SET,
    TBL_PIN_CLR
  } tbl_op_e;

  typedef struct packed {
    tbl_op_e          op;
    logic [IDX_W-1:0] ptr;
  } tbl_cmd_t;

endpackage

// ===== hw/rtl/pfes_if.sv =====
// Handshake interfaces of the pinned FIFO eviction store.
// Depends on pfes_pkg for the configuration widths.

// Request channel carrying one operation.
interface pfes_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [31:0] id;
  logic [3:0]  index;
  logic [7:0]  mode;
  logic [23:0] jpeg_len;
  logic [23:0] raw_len;
  logic [31:0] jpeg_handle;
  logic [31:0] raw_handle;

  modport source (output valid, operation, id, index, mode, jpeg_len, raw_len,
                  jpeg_handle, raw_handle, input ready);
  modport sink (input valid, operation, id, index, mode, jpeg_len, raw_len,
                jpeg_handle, raw_handle, output ready);
endinterface

// Result channel.
interface pfes_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        last;
  logic [31:0] entry_id;
  logic [7:0]  entry_mode;
  logic [23:0] entry_jpeg_len;
  logic [23:0] entry_raw_len;
  logic [31:0] entry_jpeg_handle;
  logic [31:0] entry_raw_handle;
  logic        entry_pinned;
  logic [4:0]  entry_count;
  logic [23:0] used_bytes;

  modport source (output valid, status, last, entry_id, entry_mode, entry_jpeg_len,
                  entry_raw_len, entry_jpeg_handle, entry_raw_handle, entry_pinned,
                  entry_count, used_bytes, input ready);
  modport sink (input valid, status, last, entry_id, entry_mode, entry_jpeg_len,
                entry_raw_len, entry_jpeg_handle, entry_raw_handle, entry_pinned,
                entry_count, used_bytes, output ready);
endinterface

// Configuration write channel.
interface pfes_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [pfes_pkg::CFG_IDX_W-1:0]    index;
  logic [pfes_pkg::CFG_DAT_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/pinned_fifo_eviction_store.sv =====
// Pinned FIFO eviction store: top level with the operation sequencer.
// Depends on pfes_pkg, the interfaces in pfes_if, pfes_table and pfes_ram.
//
// Usage: one request on in_i carries an operation (init, add, remove, pin,
// unpin, find by id, read by index, clear). The block drops ready while it
// works and answers with one or more results on out_o, the final one marked
// by last. Every result of a request carries the entry count and byte total
// as they stand once the whole request is done.
// Work is done by one sequencer that visits one table slot per cycle through
// a single read pointer. Find-type requests scan from the newest slot, an add
// alternates a budget check with an eviction search from the oldest slot,
// and clear reports each stored entry and then its final result.
// Results are queued in a small RAM and drained while out_o is ready, each
// read from the RAM and then shown; a stalled receiver simply holds the block
// in its draining state.
// The configuration port cfg_i is always ready; register 0 is the byte budget
// and register 1 the boot count. Reset empties the table, sets the next id to
// one and loads the default budget and boot count; no clearing pass is needed.
module pinned_fifo_eviction_store (
  input  logic   clk_i,
  input  logic   rst_ni,
  pfes_in_if.sink    in_i,
  pfes_out_if.source out_o,
  pfes_cfg_if.sink   cfg_i
);
  import pfes_pkg::*;

  // Sequencer states.
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_INIT     = 4'd1;
  localparam logic [3:0] S_CLEAR    = 4'd2;
  localparam logic [3:0] S_SCAN     = 4'd3;
  localparam logic [3:0] S_UNPIN    = 4'd4;
  localparam logic [3:0] S_READ     = 4'd5;
  localparam logic [3:0] S_ADD_CHK  = 4'd6;
  localparam logic [3:0] S_ADD_VICT = 4'd7;
  localparam logic [3:0] S_OUT_RD   = 4'd8;
  localparam logic [3:0] S_OUT_SHOW = 4'd9;

  logic [3:0]        state_q, state_d;
  logic [CNT_W-1:0]  ptr_q, ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [24:0]       bytes_q, bytes_d;
  logic [31:0]       next_id_q, next_id_d;
  logic [RES_AW-1:0] wr_q, wr_d;
  logic [RES_AW-1:0] rd_q, rd_d;
  logic [23:0]       arena_q;
  logic [15:0]       boot_q;

  // Captured request.
  logic [2:0]  op_q;
  logic [31:0] id_q;
  ent_t        item_q;
  logic [24:0] need_q;

  tbl_cmd_t tbl_cmd;
  ent_t     new_ent;
  ent_t     rd_ent;
  logic     q_we;
  res_t     q_res;
  res_t     out_res;
  logic [RES_W-1:0] ram_rdata;

  logic        id_hit;
  logic        in_range;
  logic [25:0] fit_sum;
  logic        over_budget;
  logic        need_room;
  logic [24:0] drop_len;
  logic        accept;

  assign accept   = in_i.valid && in_i.ready;
  assign id_hit   = (rd_ent.id == id_q);
  assign in_range = (ptr_q < count_q);
  assign fit_sum  = {1'b0, bytes_q} + {1'b0, need_q};
  assign over_budget = (fit_sum > {2'b00, arena_q});
  assign need_room   = (count_q != '0) &&
                       (over_budget || (count_q >= CNT_W'(MAX_ENTRIES)));
  assign drop_len = {1'b0, rd_ent.jpeg_len} + {1'b0, rd_ent.raw_len};

  // The new entry as it goes into slot 0.
  always_comb begin
    new_ent        = item_q;
    new_ent.id     = next_id_q;
    new_ent.pinned = 1'b0;
  end

  // Configuration registers.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arena_q <= ARENA_RST;
      boot_q  <= BOOT_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_ARENA: arena_q <= cfg_i.data;
        CFG_BOOT:  boot_q  <= cfg_i.data[15:0];
        default: ;
      endcase
    end
  end

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q               <= in_i.operation;
      id_q               <= in_i.id;
      item_q.id          <= '0;
      item_q.mode        <= in_i.mode;
      item_q.jpeg_len    <= in_i.jpeg_len;
      item_q.raw_len     <= in_i.raw_len;
      item_q.jpeg_handle <= in_i.jpeg_handle;
      item_q.raw_handle  <= in_i.raw_handle;
      item_q.pinned      <= 1'b0;
      need_q             <= {1'b0, in_i.jpeg_len} + {1'b0, in_i.raw_len};
    end
  end

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    count_d   = count_q;
    bytes_d   = bytes_q;
    next_id_d = next_id_q;
    wr_d      = wr_q;
    rd_d      = rd_q;
    tbl_cmd.op  = TBL_NONE;
    tbl_cmd.ptr = ptr_q[IDX_W-1:0];
    q_we      = 1'b0;
    q_res     = '0;

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          wr_d  = '0;
          rd_d  = '0;
          ptr_d = '0;
          case (in_i.operation)
            OP_INIT:  state_d = S_INIT;
            OP_ADD:   state_d = S_ADD_CHK;
            OP_READ: begin
              ptr_d   = {{(CNT_W-4){1'b0}}, in_i.index};
              state_d = S_READ;
            end
            OP_CLEAR: state_d = S_CLEAR;
            default:  state_d = S_SCAN;
          endcase
        end
      end

      S_INIT: begin
        q_we      = 1'b1;
        q_res.status = STAT_OK;
        count_d   = '0;
        bytes_d   = '0;
        next_id_d = {boot_q, 16'h0001};
        wr_d      = wr_q + 1'b1;
        state_d   = S_OUT_RD;
      end

      // Report every stored entry, then wipe the table.
      S_CLEAR: begin
        q_we = 1'b1;
        wr_d = wr_q + 1'b1;
        if (in_range) begin
          q_res.status = STAT_RELEASED;
          q_res.ent    = rd_ent;
          ptr_d        = ptr_q + 1'b1;
        end else begin
          q_res.status = STAT_OK;
          count_d      = '0;
          bytes_d      = '0;
          state_d      = S_OUT_RD;
        end
      end

      // Search by id for remove, pin, unpin and find.
      S_SCAN: begin
        if (!in_range) begin
          q_we         = 1'b1;
          q_res.status = STAT_NOTFOUND;
          wr_d         = wr_q + 1'b1;
          state_d      = S_OUT_RD;
        end else if (id_hit) begin
          q_we         = 1'b1;
          q_res.status = STAT_OK;
          q_res.ent    = rd_ent;
          wr_d         = wr_q + 1'b1;
          state_d      = S_OUT_RD;
          case (op_q)
            OP_REMOVE: begin
              tbl_cmd.op = TBL_DROP;
              bytes_d    = bytes_q - drop_len;
              count_d    = count_q - 1'b1;
            end
            OP_PIN: begin
              tbl_cmd.op          = TBL_PIN_SET;
              q_res.ent.pinned    = 1'b1;
            end
            OP_UNPIN: begin
              tbl_cmd.op          = TBL_PIN_CLR;
              q_res.ent.pinned    = 1'b0;
              ptr_d               = ptr_q + 1'b1;
              state_d             = S_UNPIN;
            end
            default: ;
          endcase
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end

      // Unpin continues over the remaining entries with the same id.
      S_UNPIN: begin
        if (!in_range) begin
          state_d = S_OUT_RD;
        end else begin
          if (id_hit) begin
            tbl_cmd.op = TBL_PIN_CLR;
          end
          ptr_d = ptr_q + 1'b1;
        end
      end

      S_READ: begin
        q_we = 1'b1;
        wr_d = wr_q + 1'b1;
        if (in_range) begin
          q_res.status = STAT_OK;
          q_res.ent    = rd_ent;
        end else begin
          q_res.status = STAT_NOTFOUND;
        end
        state_d = S_OUT_RD;
      end

      // Decide between evicting, rejecting and inserting.
      S_ADD_CHK: begin
        if (need_room) begin
          ptr_d   = count_q - 1'b1;
          state_d = S_ADD_VICT;
        end else if (over_budget) begin
          q_we         = 1'b1;
          q_res.status = STAT_TOOBIG;
          wr_d         = wr_q + 1'b1;
          state_d      = S_OUT_RD;
        end else begin
          tbl_cmd.op   = TBL_INSERT;
          q_we         = 1'b1;
          q_res.status = STAT_OK;
          q_res.ent    = new_ent;
          wr_d         = wr_q + 1'b1;
          next_id_d    = next_id_q + 1'b1;
          bytes_d      = bytes_q + need_q;
          count_d      = count_q + 1'b1;
          state_d      = S_OUT_RD;
        end
      end

      // Walk from the oldest entry towards the newest for one that is unpinned.
      S_ADD_VICT: begin
        if (!rd_ent.pinned) begin
          q_we         = 1'b1;
          q_res.status = STAT_RELEASED;
          q_res.ent    = rd_ent;
          wr_d         = wr_q + 1'b1;
          tbl_cmd.op   = TBL_DROP;
          bytes_d      = bytes_q - drop_len;
          count_d      = count_q - 1'b1;
          state_d      = S_ADD_CHK;
        end else if (ptr_q == '0) begin
          q_we         = 1'b1;
          q_res.status = STAT_NOROOM;
          wr_d         = wr_q + 1'b1;
          state_d      = S_OUT_RD;
        end else begin
          ptr_d = ptr_q - 1'b1;
        end
      end

      S_OUT_RD: begin
        state_d = S_OUT_SHOW;
      end

      S_OUT_SHOW: begin
        if (out_o.ready) begin
          rd_d = rd_q + 1'b1;
          if ((rd_q + 1'b1) == wr_q) begin
            state_d = S_IDLE;
          end else begin
            state_d = S_OUT_RD;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control and bookkeeping registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ptr_q     <= '0;
      count_q   <= '0;
      bytes_q   <= '0;
      next_id_q <= 32'd1;
      wr_q      <= '0;
      rd_q      <= '0;
    end else begin
      state_q   <= state_d;
      ptr_q     <= ptr_d;
      count_q   <= count_d;
      bytes_q   <= bytes_d;
      next_id_q <= next_id_d;
      wr_q      <= wr_d;
      rd_q      <= rd_d;
    end
  end

  pfes_table u_table (
    .clk_i     (clk_i),
    .cmd_i     (tbl_cmd),
    .new_ent_i (new_ent),
    .rd_ent_o  (rd_ent)
  );

  // Result queue.
  pfes_ram #(
    .WIDTH (RES_W),
    .DEPTH (MAX_RES)
  ) u_res_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (wr_q),
    .wdata_i (q_res),
    .raddr_i (rd_q),
    .rdata_o (ram_rdata)
  );

  assign out_res = res_t'(ram_rdata);

  // Request and result ports.
  assign in_i.ready              = (state_q == S_IDLE);
  assign out_o.valid             = (state_q == S_OUT_SHOW);
  assign out_o.status            = out_res.status;
  assign out_o.last              = ((rd_q + 1'b1) == wr_q);
  assign out_o.entry_id          = out_res.ent.id;
  assign out_o.entry_mode        = out_res.ent.mode;
  assign out_o.entry_jpeg_len    = out_res.ent.jpeg_len;
  assign out_o.entry_raw_len     = out_res.ent.raw_len;
  assign out_o.entry_jpeg_handle = out_res.ent.jpeg_handle;
  assign out_o.entry_raw_handle  = out_res.ent.raw_handle;
  assign out_o.entry_pinned      = out_res.ent.pinned;
  assign out_o.entry_count       = count_q;
  assign out_o.used_bytes        = bytes_q[23:0];

endmodule

// ===== hw/rtl/pfes_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pfes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/pfes_table.sv =====
// Entry table of the pinned FIFO eviction store, newest entry at slot 0.
// Depends on pfes_pkg for the entry and command types.
module pfes_table (
  input  logic               clk_i,
  input  pfes_pkg::tbl_cmd_t cmd_i,
  input  pfes_pkg::ent_t     new_ent_i,
  output pfes_pkg::ent_t     rd_ent_o
);
  import pfes_pkg::*;

  ent_t slot_q [MAX_ENTRIES];

  // The slot under the pointer is the one the sequencer looks at.
  assign rd_ent_o = slot_q[cmd_i.ptr];

  // Each slot loads from its neighbour on insert and drop, or changes its pin mark.
  for (genvar j = 0; j < MAX_ENTRIES; j++) begin : g_slot
    always_ff @(posedge clk_i) begin
      case (cmd_i.op)
        TBL_INSERT: begin
          if (j == 0) begin
            slot_q[j] <= new_ent_i;
          end else begin
            slot_q[j] <= slot_q[(j > 0) ? j - 1 : 0];
          end
        end
        TBL_DROP: begin
          if ((j < MAX_ENTRIES - 1) && (IDX_W'(j) >= cmd_i.ptr)) begin
            slot_q[j] <= slot_q[(j < MAX_ENTRIES - 1) ? j + 1 : j];
          end
        end
        TBL_PIN_SET: begin
          if (IDX_W'(j) == cmd_i.ptr) begin
            slot_q[j].pinned <= 1'b1;
          end
        end
        TBL_PIN_CLR: begin
          if (IDX_W'(j) == cmd_i.ptr) begin
            slot_q[j].pinned <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/pfes_checker.sv =====
// Port-level checks for the pinned FIFO eviction store.
// Depends on the top level's ports; bound to it at the end of this file.
module pfes_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_last,
  input logic [2:0] out_status,
  input logic [4:0] out_count
);

  // No result is offered while a new request can be taken.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready)
    else $error("result offered while request port ready");

  // An accepted request makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request port still ready after a request");

  // Status codes stay within the defined set.
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (out_status <= 3'd4))
    else $error("undefined status");

  // The entry count never exceeds the table size.
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (out_count <= 5'd16))
    else $error("entry count beyond table size");

  // A stalled result stays offered.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_last)))
    else $error("stalled result withdrawn");

endmodule

bind pinned_fifo_eviction_store pfes_checker u_pfes_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (in_i.valid),
  .in_ready   (in_i.ready),
  .out_valid  (out_o.valid),
  .out_ready  (out_o.ready),
  .out_last   (out_o.last),
  .out_status (out_o.status),
  .out_count  (out_o.entry_count)
);
